// ===== hdl/kbt_pkg.sv =====
// ============================================================================
// kbt_pkg
// Shared types and constants for the keyed balance table: request kinds,
// result status codes, field widths and the controller-to-datapath link.
// ============================================================================
`default_nettype none

package kbt_pkg;

    // Field widths fixed by the stream format.
    localparam int unsigned KEY_W    = 32;
    localparam int unsigned BAL_W    = 32;
    localparam int unsigned STATUS_W = 2;

    // Request kind carried on the slave tuser.
    typedef enum logic {
        REQ_CREATE = 1'b0,
        REQ_MODIFY = 1'b1
    } t_req_type;

    // Result status carried on the master tuser.
    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_EXISTS    = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    // Commands from the sequencer to the datapath.
    typedef struct packed {
        logic load_req;   // capture the incoming request
        logic cap_match;  // register the key compare vector
        logic cap_index;  // register the hit flag and matching slot
        logic rd_en;      // read the balance of the matching slot
        logic commit;     // update the table and load the result register
    } t_ctrl_cmd;

    // Status from the datapath to the sequencer.
    typedef struct packed {
        logic out_free;   // result register can take a new result this cycle
    } t_ctrl_sts;

endpackage

`default_nettype wire

// ===== hdl/kbt_ctrl.sv =====
// ============================================================================
// kbt_ctrl
// Request sequencer: walks one request through compare, encode, balance read
// and update, and holds the update until the result register is free.
// ============================================================================
`default_nettype none

module kbt_ctrl (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_req_valid,
    output logic                   o_req_ready,
    input  kbt_pkg::t_ctrl_sts     i_sts,
    output kbt_pkg::t_ctrl_cmd     o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_MATCH  = 5'b00010,
        S_ENCODE = 5'b00100,
        S_READ   = 5'b01000,
        S_UPDATE = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    // Next state and command decode.
    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_req_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    o_cmd.load_req = 1'b1;
                    n_state        = S_MATCH;
                end
            end
            S_MATCH: begin
                o_cmd.cap_match = 1'b1;
                n_state         = S_ENCODE;
            end
            S_ENCODE: begin
                o_cmd.cap_index = 1'b1;
                n_state         = S_READ;
            end
            S_READ: begin
                o_cmd.rd_en = 1'b1;
                n_state     = S_UPDATE;
            end
            S_UPDATE: begin
                // Wait here while an earlier result is still unclaimed.
                if (i_sts.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/kbt_datapath.sv =====
// ============================================================================
// kbt_datapath
// Key cells with parallel compare, slot encoder, balance memory, adder and
// the result register of the keyed balance table.
// ============================================================================
`default_nettype none

module kbt_datapath #(
    parameter int unsigned MAX_ENTRIES = 128
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  kbt_pkg::t_ctrl_cmd                 i_cmd,
    output kbt_pkg::t_ctrl_sts                 o_sts,
    input  kbt_pkg::t_req_type                 i_req_type,
    input  wire [kbt_pkg::KEY_W-1:0]           i_key_id,
    input  wire signed [kbt_pkg::BAL_W-1:0]    i_delta,
    output logic                               o_res_valid,
    input  wire                                i_res_ready,
    output kbt_pkg::t_status                   o_status,
    output logic signed [kbt_pkg::BAL_W-1:0]   o_new_balance
);

    localparam int unsigned IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int unsigned CNT_W = $clog2(MAX_ENTRIES + 1);

    // Captured request.
    kbt_pkg::t_req_type                r_type;
    logic [kbt_pkg::KEY_W-1:0]         r_key;
    logic signed [kbt_pkg::BAL_W-1:0]  r_delta;

    // Table state: key cells, fill count, balance memory.
    logic [kbt_pkg::KEY_W-1:0]         r_key_cell [MAX_ENTRIES];
    logic [CNT_W-1:0]                  r_fill;
    logic signed [kbt_pkg::BAL_W-1:0]  r_bal_mem [MAX_ENTRIES];
    logic signed [kbt_pkg::BAL_W-1:0]  r_rd_data;

    // Lookup results.
    logic [MAX_ENTRIES-1:0]            n_match;
    logic [MAX_ENTRIES-1:0]            r_match;
    logic [IDX_W-1:0]                  n_idx;
    logic [IDX_W-1:0]                  r_idx;
    logic                              r_hit;

    // Result register.
    logic                              r_out_valid;
    kbt_pkg::t_status                  r_status;
    logic signed [kbt_pkg::BAL_W-1:0]  r_balance;

    // Update decode.
    logic                              is_create;
    logic                              table_full;
    logic                              create_ok;
    logic                              modify_ok;
    kbt_pkg::t_status                  n_status;
    logic signed [kbt_pkg::BAL_W-1:0]  sum;
    logic                              mem_wr_en;
    logic [IDX_W-1:0]                  mem_wr_addr;
    logic signed [kbt_pkg::BAL_W-1:0]  mem_wr_data;

    // Each cell compares its key; only slots below the fill count are live.
    always_comb begin
        for (int i = 0; i < int'(MAX_ENTRIES); i++) begin
            n_match[i] = (CNT_W'(i) < r_fill) && (r_key_cell[i] == r_key);
        end
    end

    // Keys are unique, so at most one match bit is set and an OR of the
    // slot numbers gives its index.
    always_comb begin
        n_idx = '0;
        for (int i = 0; i < int'(MAX_ENTRIES); i++) begin
            n_idx = n_idx | (r_match[i] ? IDX_W'(i) : '0);
        end
    end

    // Request capture and lookup pipeline registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_type  <= i_req_type;
            r_key   <= i_key_id;
            r_delta <= i_delta;
        end
        if (i_cmd.cap_match) begin
            r_match <= n_match;
        end
        if (i_cmd.cap_index) begin
            r_idx <= n_idx;
            r_hit <= |r_match;
        end
    end

    // Outcome of the request.
    always_comb begin
        is_create  = (r_type == kbt_pkg::REQ_CREATE);
        table_full = (r_fill == CNT_W'(MAX_ENTRIES));
        create_ok  = is_create && !r_hit && !table_full;
        modify_ok  = !is_create && r_hit;
        sum        = r_rd_data + r_delta;
        if (is_create) begin
            if (r_hit) begin
                n_status = kbt_pkg::ST_EXISTS;
            end else if (table_full) begin
                n_status = kbt_pkg::ST_FULL;
            end else begin
                n_status = kbt_pkg::ST_OK;
            end
        end else begin
            n_status = r_hit ? kbt_pkg::ST_OK : kbt_pkg::ST_NOT_FOUND;
        end
        mem_wr_en   = i_cmd.commit && (create_ok || modify_ok);
        mem_wr_addr = create_ok ? r_fill[IDX_W-1:0] : r_idx;
        mem_wr_data = create_ok ? '0 : sum;
    end

    // Balance memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (mem_wr_en) begin
            r_bal_mem[mem_wr_addr] <= mem_wr_data;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= r_bal_mem[r_idx];
        end
    end

    // New key goes into the next free cell.
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && create_ok) begin
            r_key_cell[r_fill[IDX_W-1:0]] <= r_key;
        end
    end

    // Fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (i_cmd.commit && create_ok) begin
            r_fill <= r_fill + CNT_W'(1);
        end
    end

    // Result register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (i_res_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result register payload.
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_status  <= n_status;
            r_balance <= modify_ok ? sum : '0;
        end
    end

    assign o_sts.out_free = !r_out_valid || i_res_ready;
    assign o_res_valid    = r_out_valid;
    assign o_status       = r_status;
    assign o_new_balance  = r_balance;

endmodule

`default_nettype wire

// ===== hdl/keyed_balance_table.sv =====
// ============================================================================
// keyed_balance_table
// Table of keyed signed accumulators with create and modify requests.
// ============================================================================
// The block holds up to MAX_ENTRIES entries, each a 32-bit key and a 32-bit
// two's-complement balance; the table is empty after reset. A create request
// (tuser 0) adds the key with balance zero, or reports that the key exists or
// that the table is full. A modify request (tuser 1) adds delta to the
// matching balance and returns the sum, or reports that the key is not found.
// Each request yields exactly one result. Requests are handled one at a time:
// after a request is accepted it passes through key compare across all cells,
// slot encode, balance memory read and update, which loads the result register;
// the update waits while an earlier result is still unclaimed, and no new
// request is taken until the update is done. The result register lets the
// next request enter while a result still waits.
`default_nettype none

module keyed_balance_table #(
    parameter int unsigned MAX_ENTRIES = 128
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [63:0] s_axis_tdata,   // key_id [31:0], delta [63:32]
    input  wire  [0:0]  s_axis_tuser,   // req_type [0]
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [31:0] m_axis_tdata,   // new_balance [31:0]
    output logic [1:0]  m_axis_tuser    // status [1:0]
);

    kbt_pkg::t_ctrl_cmd  cmd;
    kbt_pkg::t_ctrl_sts  sts;
    kbt_pkg::t_status    status;
    logic signed [kbt_pkg::BAL_W-1:0] new_balance;

    // Request sequencer.
    kbt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (s_axis_tvalid),
        .o_req_ready (s_axis_tready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // Table datapath.
    kbt_datapath #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_req_type    (kbt_pkg::t_req_type'(s_axis_tuser[0])),
        .i_key_id      (s_axis_tdata[31:0]),
        .i_delta       (s_axis_tdata[63:32]),
        .o_res_valid   (m_axis_tvalid),
        .i_res_ready   (m_axis_tready),
        .o_status      (status),
        .o_new_balance (new_balance)
    );

    assign m_axis_tuser = status;
    assign m_axis_tdata = new_balance;

endmodule

`default_nettype wire

// ===== sim/keyed_balance_table_test.sv =====
`timescale 1ns / 1ps
// ============================================================================
// keyed_balance_table_test
// Self-checking bench for the keyed balance table.
// ============================================================================
// Requests wait in a queue that the stimulus process fills. A clocked driver
// presents them on the slave stream at the falling edge, with random gaps.
// The master side is stalled at random. A behavioral copy of the table
// predicts the status and balance of each request when it is accepted. Each
// accepted result is compared against the oldest prediction. A short directed
// pass covers the edge keys, duplicates, absent keys and wrap-around. It is
// followed by random chunks that fill the table to its limit and keep
// hitting it, and the bench drains all results between chunks.
module keyed_balance_table_test;

    localparam int unsigned TABLE_DEPTH   = 128;
    localparam int unsigned RESET_CYCLES  = 9;
    localparam int unsigned CHUNK_COUNT   = 4;
    localparam int unsigned CHUNK_ITEMS   = 460;
    localparam int unsigned SETTLE_CYCLES = 20;
    localparam int unsigned REPORT_LINES  = 100;
    localparam longint     CYCLE_LIMIT    = 1000000;
    localparam int         SIDE_SEND      = 0;
    localparam int         SIDE_RECV      = 1;

    typedef struct packed {
        kbt_pkg::t_req_type        kind;
        logic [kbt_pkg::KEY_W-1:0] key;
        logic [kbt_pkg::BAL_W-1:0] delta;
    } t_request;

    typedef struct packed {
        kbt_pkg::t_status          status;
        logic [kbt_pkg::BAL_W-1:0] balance;
    } t_reply;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;   // key_id [31:0], delta [63:32]
    logic [0:0]  s_axis_tuser;   // req_type [0]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;   // new_balance [31:0]
    logic [1:0]  m_axis_tuser;   // status [1:0]

    // Request queue, predicted results and bookkeeping.
    t_request                  request_queue[$];
    t_reply                    balance_replies[$];
    logic [kbt_pkg::KEY_W-1:0] made_keys[$];
    t_request                  next_req;
    t_request                  taken_req;
    t_reply                    taken_reply;
    t_reply                    oldest_reply;
    int unsigned               queued_count = 0;
    int unsigned               taken_count  = 0;
    int unsigned               fail_count   = 0;
    longint                    cycle_count  = 0;
    logic                      req_fire     = 1'b0;
    int                        send_gap     = 0;
    int                        recv_stall   = 0;
    int                        calm_left[2];

    // Shadow copy of the table.
    logic [kbt_pkg::KEY_W-1:0] shadow_key[TABLE_DEPTH];
    logic [kbt_pkg::BAL_W-1:0] shadow_bal[TABLE_DEPTH];
    int unsigned               shadow_fill = 0;

    keyed_balance_table #(
        .MAX_ENTRIES(TABLE_DEPTH)
    ) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    // Free-running clock, 12 ns period.
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Print one line per mismatch, up to a cap, and count every one.
    task automatic report_mismatch(input string what);
        if (fail_count < REPORT_LINES) begin
            $display("mismatch at cycle %0d: %s", cycle_count, what);
        end
        fail_count++;
    endtask

    // Apply one request to the shadow table and work out its result.
    task automatic predict_reply(input t_request req, output t_reply rep);
        int hit;
        hit = -1;
        for (int i = 0; i < int'(shadow_fill); i++) begin
            if (hit < 0 && shadow_key[i] == req.key) begin
                hit = i;
            end
        end
        rep.balance = '0;
        if (req.kind == kbt_pkg::REQ_CREATE) begin
            if (hit >= 0) begin
                rep.status = kbt_pkg::ST_EXISTS;
            end else if (shadow_fill >= TABLE_DEPTH) begin
                rep.status = kbt_pkg::ST_FULL;
            end else begin
                shadow_key[shadow_fill] = req.key;
                shadow_bal[shadow_fill] = '0;
                shadow_fill++;
                rep.status = kbt_pkg::ST_OK;
            end
        end else begin
            if (hit < 0) begin
                rep.status = kbt_pkg::ST_NOT_FOUND;
            end else begin
                shadow_bal[hit] = shadow_bal[hit] + req.delta;
                rep.balance = shadow_bal[hit];
                rep.status = kbt_pkg::ST_OK;
            end
        end
    endtask

    // Gap length: mostly none or short, a few long, with calm stretches.
    function automatic int pick_gap(input int side);
        int roll;
        if (calm_left[side] > 0) begin
            calm_left[side]--;
            return 0;
        end
        roll = $urandom_range(0, 999);
        if (roll < 8) begin
            calm_left[side] = $urandom_range(30, 90);
            return 0;
        end
        if (roll < 500) return 0;
        if (roll < 850) return $urandom_range(1, 3);
        if (roll < 970) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Amount mix: full-range random, small signed values and extremes.
    function automatic logic [kbt_pkg::BAL_W-1:0] pick_delta();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) return $urandom();
        if (roll < 80) begin
            return kbt_pkg::BAL_W'($signed($urandom_range(0, 200)) - 100);
        end
        case ($urandom_range(0, 4))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'hFFFF_FFFF;
            3: return 32'h0000_0001;
            default: return 32'h0000_0000;
        endcase
    endfunction

    // A key that was queued in some create request, or a random one if none yet.
    function automatic logic [kbt_pkg::KEY_W-1:0] pick_known_key();
        if (made_keys.size() == 0) return $urandom();
        return made_keys[$urandom_range(0, made_keys.size() - 1)];
    endfunction

    task automatic add_request(input kbt_pkg::t_req_type kind,
                               input logic [kbt_pkg::KEY_W-1:0] key,
                               input logic [kbt_pkg::BAL_W-1:0] delta);
        t_request req;
        req.kind  = kind;
        req.key   = key;
        req.delta = delta;
        request_queue.push_back(req);
        queued_count++;
        if (kind == kbt_pkg::REQ_CREATE) begin
            made_keys.push_back(key);
        end
    endtask

    // Mostly modifies of keys already created, plus new keys, duplicates,
    // near-miss keys that differ in one bit, and stray modifies.
    task automatic add_random_request();
        int                        roll;
        logic [kbt_pkg::KEY_W-1:0] key;
        roll = $urandom_range(0, 99);
        if (roll < 68) begin
            add_request(kbt_pkg::REQ_MODIFY, pick_known_key(), pick_delta());
        end else if (roll < 72) begin
            key = pick_known_key() ^ (32'h1 << $urandom_range(0, 31));
            add_request(kbt_pkg::REQ_MODIFY, key, pick_delta());
        end else if (roll < 76) begin
            add_request(kbt_pkg::REQ_MODIFY, $urandom(), pick_delta());
        end else if (roll < 88) begin
            add_request(kbt_pkg::REQ_CREATE, $urandom(), pick_delta());
        end else if (roll < 90) begin
            add_request(kbt_pkg::REQ_CREATE, $urandom_range(0, 15), pick_delta());
        end else if (roll < 96) begin
            add_request(kbt_pkg::REQ_CREATE, pick_known_key(), pick_delta());
        end else begin
            key = pick_known_key() ^ (32'h1 << $urandom_range(0, 31));
            add_request(kbt_pkg::REQ_CREATE, key, pick_delta());
        end
    endtask

    // Hold the sender until every request has been taken and answered.
    task automatic wait_for_drain();
        while (taken_count != queued_count || balance_replies.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    // Slave-side driver: present the next request once the last one is taken.
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!s_axis_tvalid || req_fire) begin
                if (send_gap > 0) begin
                    s_axis_tvalid <= 1'b0;
                    send_gap--;
                end else if (request_queue.size() > 0) begin
                    next_req = request_queue.pop_front();
                    s_axis_tdata  <= {next_req.delta, next_req.key};
                    s_axis_tuser  <= next_req.kind;
                    s_axis_tvalid <= 1'b1;
                    send_gap = pick_gap(SIDE_SEND);
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Master-side ready: random stalls between accepting cycles.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (recv_stall > 0) begin
            m_axis_tready <= 1'b0;
            recv_stall--;
        end else begin
            m_axis_tready <= 1'b1;
            recv_stall = pick_gap(SIDE_RECV);
        end
    end

    // Monitor: check results first, then predict for a newly taken request.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_fire <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (balance_replies.size() == 0) begin
                    report_mismatch($sformatf("unexpected result status %0d balance %h",
                                              m_axis_tuser, m_axis_tdata));
                end else begin
                    oldest_reply = balance_replies.pop_front();
                    if (m_axis_tuser !== oldest_reply.status) begin
                        report_mismatch($sformatf("status %0d, predicted %0d",
                                                  m_axis_tuser, oldest_reply.status));
                    end
                    if (m_axis_tdata !== oldest_reply.balance) begin
                        report_mismatch($sformatf("balance %h, predicted %h",
                                                  m_axis_tdata, oldest_reply.balance));
                    end
                end
            end
            req_fire <= s_axis_tvalid && s_axis_tready;
            if (s_axis_tvalid && s_axis_tready) begin
                taken_req.kind  = kbt_pkg::t_req_type'(s_axis_tuser[0]);
                taken_req.key   = s_axis_tdata[31:0];
                taken_req.delta = s_axis_tdata[63:32];
                predict_reply(taken_req, taken_reply);
                balance_replies.push_back(taken_reply);
                taken_count++;
            end
        end
    end

    // Watchdog on the total run length.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Stimulus sequence.
    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        m_axis_tready = 1'b0;
        calm_left[SIDE_SEND] = 0;
        calm_left[SIDE_RECV] = 0;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty table, edge keys, duplicates and wrap-around.
        // Absent key on an empty table.
        add_request(kbt_pkg::REQ_MODIFY, 32'h0000_0000, 32'h0000_0005);
        add_request(kbt_pkg::REQ_CREATE, 32'h0000_0000, 32'h0000_0000);
        // Duplicate create.
        add_request(kbt_pkg::REQ_CREATE, 32'h0000_0000, 32'h1234_5678);
        add_request(kbt_pkg::REQ_CREATE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        // Most positive, then wrap to negative, then wrap to zero.
        add_request(kbt_pkg::REQ_MODIFY, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
        add_request(kbt_pkg::REQ_MODIFY, 32'hFFFF_FFFF, 32'h0000_0001);
        add_request(kbt_pkg::REQ_MODIFY, 32'hFFFF_FFFF, 32'h8000_0000);
        // Most negative, then wrap to positive.
        add_request(kbt_pkg::REQ_MODIFY, 32'h0000_0000, 32'h8000_0000);
        add_request(kbt_pkg::REQ_MODIFY, 32'h0000_0000, 32'hFFFF_FFFF);
        add_request(kbt_pkg::REQ_MODIFY, 32'h0000_0000, 32'h0000_0000);
        // The amount is ignored on create.
        add_request(kbt_pkg::REQ_CREATE, 32'h8000_0000, 32'h7FFF_FFFF);
        // Absent key, one bit off a stored key.
        add_request(kbt_pkg::REQ_MODIFY, 32'h7FFF_FFFF, 32'h0000_0009);
        add_request(kbt_pkg::REQ_CREATE, 32'h7FFF_FFFF, 32'h8000_0000);
        add_request(kbt_pkg::REQ_MODIFY, 32'h7FFF_FFFF, 32'h5555_5555);
        add_request(kbt_pkg::REQ_MODIFY, 32'h7FFF_FFFF, 32'hAAAA_AAAA);
        add_request(kbt_pkg::REQ_MODIFY, 32'h8000_0000, 32'hFFFF_FFFF);
        // Duplicate of the top key.
        add_request(kbt_pkg::REQ_CREATE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        // Absent key, one bit off a stored key.
        add_request(kbt_pkg::REQ_MODIFY, 32'h0000_0001, 32'h0000_0001);
        wait_for_drain();

        // Random chunks; the table fills early in the run and stays full.
        for (int chunk = 0; chunk < int'(CHUNK_COUNT); chunk++) begin
            for (int n = 0; n < int'(CHUNK_ITEMS); n++) begin
                add_random_request();
            end
            wait_for_drain();
        end

        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/kbt_pkg.sv
hdl/kbt_ctrl.sv
hdl/kbt_datapath.sv
hdl/keyed_balance_table.sv
sim/keyed_balance_table_test.sv
